// ===== src/mcp_pkg.sv =====
package mcp_pkg;

	localparam logic [7:0] ACTIVE_SENSING = 8'hFE;
	localparam logic [4:0] CHANNEL_ANY    = 5'd16;

	// Upper status nibble with bit 7 removed
	typedef enum logic [2:0] {
		MSG_NOTE_OFF         = 3'd0,
		MSG_NOTE_ON          = 3'd1,
		MSG_KEY_PRESSURE     = 3'd2,
		MSG_CONTROLLER       = 3'd3,
		MSG_PROGRAM          = 3'd4,
		MSG_CHANNEL_PRESSURE = 3'd5,
		MSG_PITCH_BEND       = 3'd6,
		MSG_SYSTEM           = 3'd7
	} mcp_msg_t;

	typedef enum logic [1:0] {
		KIND_NOTE_OFF   = 2'd0,
		KIND_NOTE_ON    = 2'd1,
		KIND_CONTROLLER = 2'd2,
		KIND_PITCH_BEND = 2'd3
	} mcp_kind_t;

	typedef enum logic {
		ST_WAIT_STATUS = 1'b0,
		ST_COLLECT     = 1'b1
	} mcp_state_t;

	typedef struct packed {
		mcp_kind_t   kind;
		logic [6:0]  first;
		logic [6:0]  second;
		logic [14:0] bend;
	} mcp_event_t;

endpackage

// ===== src/midi_channel_message_parser_core.sv =====
// Channel    Handshake                  Payload
// in         in_valid / in_stall        rx_byte
// out        out_valid / out_stall      event_kind, data_first, data_second, bend_value
// config     cfg_write_en               cfg_write_data (channel filter)
//
// One byte per cycle sustained while no waiting result is stalled; a byte is registered
// on entry, decoded against the parser state as it advances, and any event lands in the
// result register.
// Reset clears the parser to wait for a status byte and sets the filter to any channel.
// A waiting result stalls the input stage only while that stage already holds a byte.
module midi_channel_message_parser_core
	import mcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [4:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [6:0]  data_first,
	output logic [6:0]  data_second,
	output logic [14:0] bend_value
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go;
	logic       evt_valid;
	mcp_event_t evt;
	mcp_event_t evt_q;

	// Advance the held byte whenever the result register has room
	assign advance = ~out_valid | ~out_stall;
	assign go      = valid_s1 & advance;

	mcp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Hold the parser state; decode one byte per advancing transaction
	mcp_decode u_dec (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.go             (go),
		.byte_s1        (byte_s1),
		.evt_valid      (evt_valid),
		.evt            (evt)
	);

	mcp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (evt_valid),
		.evt       (evt),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.evt_q     (evt_q)
	);

	assign event_kind  = evt_q.kind;
	assign data_first  = evt_q.first;
	assign data_second = evt_q.second;
	assign bend_value  = evt_q.bend;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> !(out_valid && out_stall))
		else $error("event would overwrite a waiting result");

	a_take_only_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!valid_s1 || advance))
		else $error("input taken over a held byte");

endmodule

// ===== src/mcp_in_stage.sv =====
module mcp_in_stage
	import mcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	// Stall only while a held byte cannot move on
	assign in_stall = valid_s1 & ~advance;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== src/mcp_decode.sv =====
module mcp_decode
	import mcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [4:0] cfg_write_data,
	input  logic       go,
	input  logic [7:0] byte_s1,
	output logic       evt_valid,
	output mcp_event_t evt
);

	logic [4:0] filter_q;
	mcp_state_t state_q, state_d;
	mcp_msg_t   type_q, type_d;
	logic       need_two_q, need_two_d;
	logic       held_q, held_d;
	logic [6:0] first_q, first_d;

	mcp_msg_t   in_type;
	logic       chan_ok;
	logic       is_status;
	logic       completes;
	logic [6:0] first_now;

	assign in_type   = mcp_msg_t'(byte_s1[6:4]);
	assign chan_ok   = (filter_q == CHANNEL_ANY) || (filter_q == {1'b0, byte_s1[3:0]});
	assign is_status = byte_s1[7];
	assign completes = go && !is_status && (state_q == ST_COLLECT) &&
		(held_q || !need_two_q);
	assign first_now = held_q ? first_q : byte_s1[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= CHANNEL_ANY;
		end else if (cfg_write_en) begin
			filter_q <= cfg_write_data;
		end
	end

	// Next state
	always_comb begin
		state_d    = state_q;
		type_d     = type_q;
		need_two_d = need_two_q;
		held_d     = held_q;
		first_d    = first_q;
		if (go && byte_s1 != ACTIVE_SENSING) begin
			if (is_status) begin
				held_d = 1'b0;
				if (in_type != MSG_SYSTEM && chan_ok) begin
					state_d    = ST_COLLECT;
					type_d     = in_type;
					need_two_d = !(in_type == MSG_PROGRAM ||
						in_type == MSG_CHANNEL_PRESSURE);
				end else begin
					state_d = ST_WAIT_STATUS;
				end
			end else if (state_q == ST_COLLECT) begin
				if (!held_q) begin
					first_d = byte_s1[6:0];
				end
				if (completes) begin
					state_d = ST_WAIT_STATUS;
					held_d  = 1'b0;
				end else begin
					held_d = 1'b1;
				end
			end
		end
	end

	// Event outputs
	always_comb begin
		evt_valid  = 1'b0;
		evt.kind   = KIND_NOTE_OFF;
		evt.first  = first_now;
		evt.second = byte_s1[6:0];
		evt.bend   = 15'd0;
		case (type_q)
			MSG_NOTE_OFF: begin
				evt_valid = completes;
				evt.kind  = KIND_NOTE_OFF;
			end
			MSG_NOTE_ON: begin
				evt_valid = completes;
				evt.kind  = KIND_NOTE_ON;
			end
			MSG_CONTROLLER: begin
				evt_valid = completes;
				evt.kind  = KIND_CONTROLLER;
			end
			MSG_PITCH_BEND: begin
				evt_valid = completes;
				evt.kind  = KIND_PITCH_BEND;
				evt.bend  = {byte_s1[6:0], 1'b0, first_now};
			end
			default: begin
				evt_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_WAIT_STATUS;
			type_q     <= MSG_NOTE_OFF;
			need_two_q <= 1'b0;
			held_q     <= 1'b0;
			first_q    <= 7'd0;
		end else begin
			state_q    <= state_d;
			type_q     <= type_d;
			need_two_q <= need_two_d;
			held_q     <= held_d;
			first_q    <= first_d;
		end
	end

	a_evt_from_collect: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> state_q == ST_COLLECT)
		else $error("event raised outside a message");

	a_evt_ends_message: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |=> state_q == ST_WAIT_STATUS && !held_q)
		else $error("message not closed after event");

	a_held_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> need_two_q && state_q == ST_COLLECT)
		else $error("first byte held for a short message");

endmodule

// ===== src/mcp_out_stage.sv =====
module mcp_out_stage
	import mcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  mcp_event_t evt,
	input  logic       out_stall,
	output logic       out_valid,
	output mcp_event_t evt_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_q <= evt;
		end
	end

endmodule

// ===== tb/tb_midi_channel_message_parser_core.sv =====
module tb_midi_channel_message_parser_core;
	import mcp_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int BYTES_PER_PHASE = 250;
	localparam int PHASE_COUNT     = 6;
	localparam int SETTLE_CYCLES   = 4;
	localparam int REPORT_CAP      = 50;

	// Parser mirror: tracks the channel filter and the message being collected,
	// and keeps the events the block still owes us, oldest first.
	class parse_scoreboard;
		logic [4:0]  filter;
		logic        collecting;
		mcp_msg_t    msg;
		logic [1:0]  need;
		logic [1:0]  held;
		logic [6:0]  first_byte;
		mcp_event_t  owed_events[$];
		int          mismatches;

		function new();
			filter     = CHANNEL_ANY;
			collecting = 1'b0;
			msg        = MSG_NOTE_OFF;
			need       = 2'd0;
			held       = 2'd0;
			first_byte = 7'd0;
			mismatches = 0;
		endfunction

		// Advance the mirror by one accepted byte; queue an event if one completes.
		function void note_byte(logic [7:0] b);
			mcp_msg_t   t;
			mcp_event_t ev;
			if (b == ACTIVE_SENSING)
				return;
			if (b[7]) begin
				t          = mcp_msg_t'(b[6:4]);
				collecting = 1'b0;
				held       = 2'd0;
				need       = 2'd0;
				if (t == MSG_SYSTEM)
					return;
				if (filter != CHANNEL_ANY && {1'b0, b[3:0]} != filter)
					return;
				msg        = t;
				collecting = 1'b1;
				need       = (t == MSG_PROGRAM || t == MSG_CHANNEL_PRESSURE) ? 2'd1 : 2'd2;
				return;
			end
			if (!collecting || need == 2'd0)
				return;
			if (held == 2'd0)
				first_byte = b[6:0];
			held = held + 2'd1;
			if (held < need)
				return;
			collecting = 1'b0;
			held       = 2'd0;
			need       = 2'd0;
			case (msg)
				MSG_NOTE_OFF:   ev.kind = KIND_NOTE_OFF;
				MSG_NOTE_ON:    ev.kind = KIND_NOTE_ON;
				MSG_CONTROLLER: ev.kind = KIND_CONTROLLER;
				MSG_PITCH_BEND: ev.kind = KIND_PITCH_BEND;
				default:        return;
			endcase
			ev.first  = first_byte;
			ev.second = b[6:0];
			// bit 7 of the bend word stays clear
			ev.bend   = (ev.kind == KIND_PITCH_BEND) ? {b[6:0], 1'b0, first_byte} : 15'd0;
			owed_events.push_back(ev);
		endfunction

		task report_mismatch(string what);
			if (mismatches < REPORT_CAP)
				$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_event(mcp_event_t got);
			mcp_event_t want;
			if (owed_events.size() == 0) begin
				report_mismatch($sformatf("event with none owed: kind %0d first %0d second %0d",
					got.kind, got.first, got.second));
				return;
			end
			want = owed_events.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
			if (got.first !== want.first)
				report_mismatch($sformatf("data_first %0d, want %0d", got.first, want.first));
			if (got.second !== want.second)
				report_mismatch($sformatf("data_second %0d, want %0d", got.second, want.second));
			if (got.bend !== want.bend)
				report_mismatch($sformatf("bend_value %0d, want %0d", got.bend, want.bend));
		endtask
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_write_en   = 1'b0;
	logic [4:0]  cfg_write_data = 5'd0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte        = 8'd0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [1:0]  event_kind;
	logic [6:0]  data_first;
	logic [6:0]  data_second;
	logic [14:0] bend_value;

	parse_scoreboard sb = new();

	int         idle_pct   = 0;
	int         stall_pct  = 0;
	int         bytes_sent = 0;
	int         quiet_run  = 0;
	logic [4:0] filter_now = CHANNEL_ANY;

	midi_channel_message_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.data_first    (data_first),
		.data_second   (data_second),
		.bend_value    (bend_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver back-pressure: redraw the stall at every falling edge.
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < stall_pct);
	end

	// Observe every transaction at the rising edge, before the block's registers move.
	// Order within the edge is fixed here: config, then result, then input byte.
	// The same block keeps the watchdog, which counts edges with no result or input byte taken.
	always @(posedge clk) begin : observe
		mcp_event_t seen;
		logic       moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_write_en)
				sb.filter = cfg_write_data;
			if (out_valid && !out_stall) begin
				seen.kind   = mcp_kind_t'(event_kind);
				seen.first  = data_first;
				seen.second = data_second;
				seen.bend   = bend_value;
				sb.check_event(seen);
				moved = 1'b1;
			end
			if (in_valid && !in_stall) begin
				sb.note_byte(rx_byte);
				moved = 1'b1;
			end
		end
		quiet_run = moved ? 0 : quiet_run + 1;
		if (quiet_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [7:0] status_of(mcp_msg_t m, logic [3:0] ch);
		return {1'b1, m, ch};
	endfunction

	// Mostly uniform data, with the two extremes drawn more often.
	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'd0;
		if (r < 16)
			return 8'd127;
		return 8'($urandom_range(0, 127));
	endfunction

	// Present one byte at a falling edge, idling first at random, and hold it
	// until the block takes it. Valid stays high into a following byte unless an idle is drawn.
	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// Drop valid and wait until every owed event has come out, then let the
	// pipeline settle, since a silent message may still be in flight.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.owed_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_filter(logic [4:0] v);
		@(negedge clk);
		cfg_write_en   = 1'b1;
		cfg_write_data = v;
		filter_now     = v;
		@(negedge clk);
		cfg_write_en   = 1'b0;
	endtask

	// One channel message with random content. A minority is broken: noise
	// bytes slipped in, active sensing mid-message, or data cut short.
	task automatic send_message();
		mcp_msg_t   mt;
		logic [3:0] ch;
		int         n_data;
		if ($urandom_range(0, 99) < 5)
			send_byte(8'($urandom_range(0, 255)));
		if (filter_now < CHANNEL_ANY && $urandom_range(0, 3) != 0)
			ch = filter_now[3:0];
		else
			ch = 4'($urandom_range(0, 15));
		mt     = mcp_msg_t'($urandom_range(0, 6));
		n_data = (mt == MSG_PROGRAM || mt == MSG_CHANNEL_PRESSURE) ? 1 : 2;
		if ($urandom_range(0, 99) < 5)
			n_data--;
		send_byte(status_of(mt, ch));
		for (int i = 0; i < n_data; i++) begin
			if ($urandom_range(0, 99) < 4)
				send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 3)
				send_byte(ACTIVE_SENSING);
			send_byte(pick_data());
		end
	endtask

	initial begin
		logic [4:0] phase_filter;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: filter at its reset value, no idling.
		// note on, key 0, velocity zero, with active sensing between the data bytes
		send_byte(status_of(MSG_NOTE_ON, 4'd0));
		send_byte(8'd0);
		send_byte(ACTIVE_SENSING);
		send_byte(8'd0);
		// note off on the top channel, both data bytes at their maximum
		send_byte(status_of(MSG_NOTE_OFF, 4'd15));
		send_byte(8'd127);
		send_byte(8'd127);
		// largest pitch bend
		send_byte(status_of(MSG_PITCH_BEND, 4'd5));
		send_byte(8'd127);
		send_byte(8'd127);
		// a status byte cuts a note short; the controller change that follows completes
		send_byte(status_of(MSG_NOTE_ON, 4'd0));
		send_byte(8'd60);
		send_byte(status_of(MSG_CONTROLLER, 4'd3));
		send_byte(8'd64);
		send_byte(8'd127);
		// messages consumed without an event
		send_byte(status_of(MSG_PROGRAM, 4'd0));
		send_byte(8'd5);
		send_byte(status_of(MSG_CHANNEL_PRESSURE, 4'd0));
		send_byte(8'd16);
		send_byte(status_of(MSG_KEY_PRESSURE, 4'd0));
		send_byte(8'd1);
		send_byte(8'd2);
		// a system byte aborts the note; the late data byte is stray
		send_byte(status_of(MSG_NOTE_ON, 4'd1));
		send_byte(8'd60);
		send_byte(status_of(MSG_SYSTEM, 4'd8));
		send_byte(8'd64);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			case (p)
				0:       phase_filter = 5'd0;
				1:       phase_filter = 5'd15;
				2:       phase_filter = 5'd31;
				3:       phase_filter = CHANNEL_ANY;
				4:       phase_filter = 5'($urandom_range(1, 14));
				default: phase_filter = 5'($urandom_range(17, 30));
			endcase
			write_filter(phase_filter);
			case (p % 4)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 73; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			bytes_sent = 0;
			while (bytes_sent < BYTES_PER_PHASE)
				send_message();
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed_events.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
